FILE: design/epp_pkg.sv
// Shared constants, register index codes and helpers for the ellipse plane projection unit.
// No dependencies.
package epp_pkg;

  localparam int CompWidth  = 20;
  localparam int VecWidth   = 3 * CompWidth;
  localparam int AngleBits  = 16;
  localparam int IndexBits  = 10;
  localparam int CordicSteps = 16;

  // Register index codes on the configuration port
  localparam logic [2:0] REG_CENTER   = 3'd0;
  localparam logic [2:0] REG_AXIS_U   = 3'd1;
  localparam logic [2:0] REG_AXIS_V   = 3'd2;
  localparam logic [2:0] REG_NORMAL   = 3'd3;
  localparam logic [2:0] REG_HNORM    = 3'd4;
  localparam logic [2:0] REG_INV_HNORM = 3'd5;
  localparam logic [2:0] REG_STEP     = 3'd6;

  localparam logic [18:0] TwoPiQ16   = 19'd411775;
  localparam logic signed [19:0] CordicGain = 20'sd39797;

  typedef logic signed [CompWidth-1:0] comp_t;

  function automatic comp_t vec_comp(input logic [VecWidth-1:0] v, input int k);
    vec_comp = comp_t'(v[k*CompWidth +: CompWidth]);
  endfunction

  function automatic logic signed [19:0] atan_q16(input int k);
    case (k)
      0:       atan_q16 = 20'sd51472;
      1:       atan_q16 = 20'sd30386;
      2:       atan_q16 = 20'sd16055;
      3:       atan_q16 = 20'sd8150;
      4:       atan_q16 = 20'sd4091;
      5:       atan_q16 = 20'sd2047;
      6:       atan_q16 = 20'sd1024;
      7:       atan_q16 = 20'sd512;
      8:       atan_q16 = 20'sd256;
      9:       atan_q16 = 20'sd128;
      10:      atan_q16 = 20'sd64;
      11:      atan_q16 = 20'sd32;
      12:      atan_q16 = 20'sd16;
      13:      atan_q16 = 20'sd8;
      14:      atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

endpackage

FILE: design/ellipse_plane_projection_unit.sv
// Ellipse plane projection unit: streams point indices to projected screen coordinates.
// Depends on epp_pkg (constants, register codes, CORDIC arctangent table).
// Throughput: one point per cycle; the whole pipeline advances on one enable, held
// only while the output register holds an unaccepted result.
// Timing is set by the 16-stage CORDIC and the multiplier stages of the view transform.
// Reset (rst_n low, synchronous) clears all valid bits and the configuration registers.
module ellipse_plane_projection_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [59:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [9:0]          in_point_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [23:0]  out_screen_x,
  output logic signed [23:0]  out_screen_y
);

  localparam int Depth = 30;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [59:0] center_r, axis_u_r, axis_v_r, normal_r;
  logic [19:0] hnorm_r;
  logic [23:0] inv_r;
  logic [15:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      axis_u_r <= '0;
      axis_v_r <= '0;
      normal_r <= '0;
      hnorm_r  <= '0;
      inv_r    <= '0;
      step_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        epp_pkg::REG_CENTER:    center_r <= cfg_wdata;
        epp_pkg::REG_AXIS_U:    axis_u_r <= cfg_wdata;
        epp_pkg::REG_AXIS_V:    axis_v_r <= cfg_wdata;
        epp_pkg::REG_NORMAL:    normal_r <= cfg_wdata;
        epp_pkg::REG_HNORM:     hnorm_r  <= cfg_wdata[19:0];
        epp_pkg::REG_INV_HNORM: inv_r    <= cfg_wdata[23:0];
        epp_pkg::REG_STEP:      step_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  epp_pkg::comp_t nrm [3];
  logic           tilted;   // normal has a horizontal part
  always_comb begin
    for (int j = 0; j < 3; j++) nrm[j] = epp_pkg::vec_comp(normal_r, j);
    tilted = (nrm[0] != '0) || (nrm[1] != '0);
  end

  // ---------------------------------------------------------------------------
  // Plane projection of c, u, v: a - (a.n)n. Depends on configuration only, so
  // it runs free; its four stages settle long before a point reaches its use.
  // ---------------------------------------------------------------------------
  epp_pkg::comp_t src [3][3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      src[0][j] = epp_pkg::vec_comp(center_r, j);
      src[1][j] = epp_pkg::vec_comp(axis_u_r, j);
      src[2][j] = epp_pkg::vec_comp(axis_v_r, j);
    end
  end

  logic signed [39:0] pa_r   [3][3];
  logic signed [41:0] dot_r  [3];
  logic signed [61:0] pd_r   [3][3];
  logic signed [26:0] proj_r [3][3];
  logic signed [61:0] pd_rnd [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        pd_rnd[i][j] = pd_r[i][j] + (62'sd1 <<< 35);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) pa_r[i][j] <= src[i][j] * nrm[j];
      dot_r[i] <= 42'(pa_r[i][0]) + 42'(pa_r[i][1]) + 42'(pa_r[i][2]);
      for (int j = 0; j < 3; j++) begin
        pd_r[i][j]   <= dot_r[i] * nrm[j];
        proj_r[i][j] <= 27'(src[i][j]) - 27'($signed(pd_rnd[i][j][61:36]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one enable for all stages, valid bits travel with data
  // ---------------------------------------------------------------------------
  logic             en;
  logic [Depth-1:0] vld_r;

  assign en       = !vld_r[Depth-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Depth-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Phase and reduction to -1/4..+1/4 turn
  // ---------------------------------------------------------------------------
  logic [25:0] phase_full;
  logic [15:0] phase_r;
  logic [14:0] q;
  logic        wrap;
  logic [14:0] mag_r;
  logic        msgn_r, mneg_r;
  logic [33:0] rad_full;
  logic signed [19:0] rad;

  assign phase_full = in_point_index * step_r;
  assign q          = phase_r[14:0];
  assign wrap       = q > 15'd16384;
  assign rad_full   = mag_r * epp_pkg::TwoPiQ16 + 34'd32768;
  assign rad        = $signed({2'b00, rad_full[33:16]});

  // CORDIC state, index 0 is the start vector
  logic signed [19:0] cx_r [epp_pkg::CordicSteps+1];
  logic signed [19:0] cy_r [epp_pkg::CordicSteps+1];
  logic signed [19:0] cz_r [epp_pkg::CordicSteps+1];
  logic               cn_r [epp_pkg::CordicSteps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= phase_full[15:0];
      mag_r   <= wrap ? 15'(16'd32768 - {1'b0, q}) : q;
      msgn_r  <= wrap;
      mneg_r  <= phase_r[15] ^ wrap;
      cx_r[0] <= epp_pkg::CordicGain;
      cy_r[0] <= '0;
      cz_r[0] <= msgn_r ? -rad : rad;
      cn_r[0] <= mneg_r;
    end
  end

  for (genvar k = 0; k < epp_pkg::CordicSteps; k++) begin : g_cordic
    logic signed [19:0] dx, dy;
    assign dx = cy_r[k] >>> k;
    assign dy = cx_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz_r[k] >= 0) begin
          cx_r[k+1] <= cx_r[k] - dx;
          cy_r[k+1] <= cy_r[k] + dy;
          cz_r[k+1] <= cz_r[k] - epp_pkg::atan_q16(k);
        end else begin
          cx_r[k+1] <= cx_r[k] + dx;
          cy_r[k+1] <= cy_r[k] - dy;
          cz_r[k+1] <= cz_r[k] + epp_pkg::atan_q16(k);
        end
        cn_r[k+1] <= cn_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Ellipse point r = pc + pu*cos + pv*sin, then the view transform
  // ---------------------------------------------------------------------------
  localparam int L = epp_pkg::CordicSteps;

  logic signed [19:0] cs_r, sn_r;
  logic signed [46:0] mu_r [3], mv_r [3];
  logic signed [47:0] rs   [3];
  logic signed [32:0] r_r  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) rs[j] = 48'(mu_r[j]) + 48'(mv_r[j]) + 48'sd32768;
  end

  logic signed [52:0] m_a_r, m_b_r, m_c_r, m_d_r;
  logic signed [53:0] m_e_r;
  logic signed [33:0] px_r [5], py_r [5];
  logic signed [53:0] dif, sm, er;
  logic signed [35:0] t1_r, t2_r, t3_r [4];
  logic signed [60:0] p1_r;
  logic signed [55:0] p2_r;
  logic signed [60:0] p1_rnd;
  logic signed [55:0] p2_rnd;
  logic signed [48:0] x2_r [2];
  logic signed [37:0] t2b_r;
  logic signed [62:0] p3_r, p3_rnd;
  logic signed [51:0] y2;
  logic signed [51:0] xs_r, ys_r;
  logic signed [59:0] sx_r, sy_r;
  logic signed [60:0] sx_rnd, sy_rnd;
  logic signed [56:0] sx_sh, sy_sh;
  logic signed [24:0] inv_s;
  logic signed [20:0] hn_s;
  logic signed [23:0] out_x_r, out_y_r;

  assign inv_s  = $signed({1'b0, inv_r});
  assign hn_s   = $signed({1'b0, hnorm_r});
  assign dif    = 54'(m_a_r) - 54'(m_b_r) + (54'sd1 <<< 17);
  assign sm     = 54'(m_c_r) + 54'(m_d_r) + (54'sd1 <<< 17);
  assign er     = m_e_r + (54'sd1 <<< 17);
  assign p1_rnd = p1_r + 61'sd2048;
  assign p2_rnd = p2_r + (56'sd1 <<< 17);
  assign p3_rnd = p3_r + 63'sd2048;
  assign y2     = 52'($signed(p3_rnd[62:12])) - 52'(t3_r[3]);
  assign sx_rnd = 61'(sx_r) + 61'sd8;
  assign sy_rnd = 61'(sy_r) + 61'sd8;
  assign sx_sh  = $signed(sx_rnd[60:4]);
  assign sy_sh  = $signed(sy_rnd[60:4]);

  function automatic logic signed [23:0] sat24(input logic signed [56:0] v);
    if (v > 57'sd8388607)       sat24 = 24'sh7FFFFF;
    else if (v < -57'sd8388608) sat24 = 24'sh800000;
    else                        sat24 = v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // sign fix of the half-turn fold
      cs_r <= cn_r[L] ? -cx_r[L] : cx_r[L];
      sn_r <= cn_r[L] ? -cy_r[L] : cy_r[L];
      for (int j = 0; j < 3; j++) begin
        mu_r[j] <= proj_r[1][j] * cs_r;
        mv_r[j] <= proj_r[2][j] * sn_r;
        r_r[j]  <= 33'(proj_r[0][j]) + 33'($signed(rs[j][47:16]));
      end
      m_a_r <= nrm[1] * r_r[0];
      m_b_r <= nrm[0] * r_r[1];
      m_c_r <= r_r[0] * nrm[0];
      m_d_r <= r_r[1] * nrm[1];
      m_e_r <= r_r[2] * hn_s;
      // flat-normal view carried alongside
      px_r[0] <= 34'(r_r[0]);
      py_r[0] <= -34'(r_r[1]);
      for (int s = 1; s < 5; s++) begin
        px_r[s] <= px_r[s-1];
        py_r[s] <= py_r[s-1];
      end
      t1_r    <= $signed(dif[53:18]);
      t2_r    <= $signed(sm[53:18]);
      t3_r[0] <= $signed(er[53:18]);
      for (int s = 1; s < 4; s++) t3_r[s] <= t3_r[s-1];
      p1_r    <= t1_r * inv_s;
      p2_r    <= t2_r * nrm[2];
      x2_r[0] <= $signed(p1_rnd[60:12]);
      t2b_r   <= $signed(p2_rnd[55:18]);
      p3_r    <= t2b_r * inv_s;
      x2_r[1] <= x2_r[0];
      xs_r    <= tilted ? 52'(x2_r[1]) : 52'(px_r[4]);
      ys_r    <= tilted ? y2 : 52'(py_r[4]);
      sx_r    <= (60'(xs_r) + (60'sd15 <<< 12)) * 60'sd50;
      sy_r    <= (60'(ys_r) + (60'sd10 <<< 12)) * 60'sd50;
      out_x_r <= sat24(sx_sh);
      out_y_r <= sat24(sy_sh);
    end
  end

  assign out_screen_x = out_x_r;
  assign out_screen_y = out_y_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_out_from_prev_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[Depth-2]))
    else $error("output valid without a transaction in the previous stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && en) |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

endmodule
